// File: sv/ordered_key_list_assert.svh
// ----------------------------------------------------------------------------
// Ordered key list assertion macros
// Immediate-implication and next-cycle-implication property wrappers.
// ----------------------------------------------------------------------------
`ifndef ORDERED_KEY_LIST_ASSERT_SVH
`define ORDERED_KEY_LIST_ASSERT_SVH

`ifndef SYNTHESIS

`define OKL_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("ordered_key_list assertion failed");

`define OKL_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("ordered_key_list assertion failed");

`else

`define OKL_ASSERT_IMP(label, clk, rst_n, pre, post)

`define OKL_ASSERT_NXT(label, clk, rst_n, pre, post)

`endif

`endif

// File: sv/okl_pkg.sv
// ----------------------------------------------------------------------------
// Ordered key list package
// Operation and status codes, result type and controller states.
// ----------------------------------------------------------------------------
package okl_pkg;

    localparam int KEY_W = 32;
    localparam int OP_W  = 2;
    localparam int ST_W  = 2;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_DUMP   = 2'd2;

    localparam logic [ST_W-1:0] ST_DONE      = 2'd0;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY     = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [ST_W-1:0]         status;
        logic signed [KEY_W-1:0] value;
        logic                    last;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_DUMP,
        S_RESP
    } t_state;

endpackage

// File: sv/okl_intf.sv
// ----------------------------------------------------------------------------
// Ordered key list channel interfaces
// Request channel (op, key) and result channel (status, value, last).
// ----------------------------------------------------------------------------
interface okl_in_if import okl_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         op;
    logic signed [KEY_W-1:0] key;

    modport source (output valid, output op, output key, input ready);
    modport sink   (input valid, input op, input key, output ready);
endinterface

interface okl_out_if import okl_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [ST_W-1:0]         status;
    logic signed [KEY_W-1:0] entry_value;
    logic                    last;

    modport source (output valid, output status, output entry_value, output last,
                    input ready);
    modport sink   (input valid, input status, input entry_value, input last,
                    output ready);
endinterface

// File: sv/ordered_key_list.sv
// ----------------------------------------------------------------------------
// Ordered key list
// Newest-first list of signed keys with insert, remove and dump.
// ----------------------------------------------------------------------------
// Keys live in one synchronous RAM stored back to front, so an insert is a
// single write at the fill count and the list front is the highest used
// address. One request is worked on at a time; a new request is taken as
// soon as the previous one has handed its last result to the output
// register, even while that result still waits. A remove searches one entry
// per cycle from the front and then moves each entry in front of the match
// down by one, one per cycle. A dump streams one entry per cycle from the
// registered RAM read data while the result register is free. A stalled
// result register holds the request in progress. No clearing pass is needed
// after reset.
// ----------------------------------------------------------------------------
`include "ordered_key_list_assert.svh"

module ordered_key_list import okl_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    okl_in_if.sink    i_in,
    okl_out_if.source o_out
);

    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    t_state                  r_state;
    t_state                  n_state;
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;
    logic [ADDR_W-1:0]       r_addr;
    logic [ADDR_W-1:0]       n_addr;
    logic signed [KEY_W-1:0] r_key;
    logic signed [KEY_W-1:0] n_key;
    t_result                 r_res;
    t_result                 n_res;
    logic                    r_pend;
    logic                    n_pend;
    logic                    r_pend_last;
    logic                    n_pend_last;
    logic                    r_left;
    logic                    n_left;

    logic                    in_acc;
    logic                    full;
    logic                    empty;
    logic [ADDR_W-1:0]       cnt_m1;
    logic                    hit;
    logic                    at_front;
    logic                    free;
    logic                    move;
    logic                    issue;

    logic                    rd_en;
    logic [ADDR_W-1:0]       rd_addr;
    logic signed [KEY_W-1:0] rd_data;
    logic                    wr_en;
    logic [ADDR_W-1:0]       wr_addr;
    logic signed [KEY_W-1:0] wr_data;
    logic                    load;
    t_result                 res;

    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign full       = (r_count == CNT_W'(CAPACITY));
    assign empty      = (r_count == '0);
    assign cnt_m1     = ADDR_W'(r_count - 1'b1);
    assign hit        = (rd_data == r_key);
    assign at_front   = (r_addr == cnt_m1);
    assign move       = r_pend && free;
    assign issue      = r_left && (!r_pend || move);

    okl_ram #(
        .DEPTH  (CAPACITY),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    okl_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_res   (res),
        .o_free  (free),
        .o_out   (o_out)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_in.op)
                        OP_INSERT: n_state = S_RESP;
                        OP_REMOVE: n_state = empty ? S_RESP : S_SEARCH;
                        OP_DUMP:   n_state = empty ? S_RESP : S_DUMP;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_SEARCH: begin
                if (hit) begin
                    n_state = at_front ? S_RESP : S_SHIFT;
                end else if (r_addr == '0) begin
                    n_state = S_RESP;
                end
            end
            S_SHIFT: begin
                if (at_front) begin
                    n_state = S_RESP;
                end
            end
            S_DUMP: begin
                if (move && r_pend_last) begin
                    n_state = S_IDLE;
                end
            end
            S_RESP: begin
                if (free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_count     = r_count;
        n_addr      = r_addr;
        n_key       = r_key;
        n_res       = r_res;
        n_pend      = r_pend;
        n_pend_last = r_pend_last;
        n_left      = r_left;
        rd_en       = 1'b0;
        rd_addr     = r_addr;
        wr_en       = 1'b0;
        wr_addr     = r_addr;
        wr_data     = rd_data;
        load        = 1'b0;
        res         = r_res;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_key = i_in.key;
                    case (i_in.op)
                        OP_INSERT: begin
                            if (full) begin
                                n_res = '{status: ST_FULL, value: i_in.key, last: 1'b1};
                            end else begin
                                wr_en   = 1'b1;
                                wr_addr = r_count[ADDR_W-1:0];
                                wr_data = i_in.key;
                                n_count = r_count + 1'b1;
                                n_res   = '{status: ST_DONE, value: i_in.key, last: 1'b1};
                            end
                        end
                        OP_REMOVE: begin
                            if (empty) begin
                                n_res = '{status: ST_EMPTY, value: i_in.key, last: 1'b1};
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = cnt_m1;
                                n_addr  = cnt_m1;
                            end
                        end
                        OP_DUMP: begin
                            if (empty) begin
                                n_res = '{status: ST_EMPTY, value: '0, last: 1'b1};
                            end else begin
                                rd_en       = 1'b1;
                                rd_addr     = cnt_m1;
                                n_pend      = 1'b1;
                                n_pend_last = (cnt_m1 == '0);
                                n_left      = (cnt_m1 != '0);
                                n_addr      = cnt_m1 - 1'b1;
                            end
                        end
                        default: begin
                            n_key = r_key;
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                if (hit) begin
                    n_res = '{status: ST_DONE, value: r_key, last: 1'b1};
                    if (at_front) begin
                        n_count = r_count - 1'b1;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = r_addr + 1'b1;
                        n_addr  = r_addr + 1'b1;
                    end
                end else if (r_addr == '0) begin
                    n_res = '{status: ST_NOT_FOUND, value: r_key, last: 1'b1};
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_addr - 1'b1;
                    n_addr  = r_addr - 1'b1;
                end
            end
            S_SHIFT: begin
                wr_en   = 1'b1;
                wr_addr = r_addr - 1'b1;
                wr_data = rd_data;
                if (at_front) begin
                    n_count = r_count - 1'b1;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_addr + 1'b1;
                    n_addr  = r_addr + 1'b1;
                end
            end
            S_DUMP: begin
                if (move) begin
                    load = 1'b1;
                    res  = '{status: ST_DONE, value: rd_data, last: r_pend_last};
                end
                if (issue) begin
                    rd_en       = 1'b1;
                    rd_addr     = r_addr;
                    n_pend_last = (r_addr == '0);
                    n_left      = (r_addr != '0);
                    n_addr      = r_addr - 1'b1;
                end
                n_pend = issue || (r_pend && !move);
            end
            S_RESP: begin
                if (free) begin
                    load = 1'b1;
                    res  = r_res;
                end
            end
            default: begin
                load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_pend_last <= 1'b0;
            r_left      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_pend_last <= n_pend_last;
            r_left      <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_key  <= n_key;
        r_res  <= n_res;
    end

    `OKL_ASSERT_NXT(a_insert_grows, i_clk, i_rst_n, in_acc && (i_in.op == OP_INSERT) && !full, r_count == $past(r_count) + 1'b1)
    `OKL_ASSERT_IMP(a_load_free, i_clk, i_rst_n, load, free)
    `OKL_ASSERT_IMP(a_search_range, i_clk, i_rst_n, (r_state == S_SEARCH) || (r_state == S_SHIFT), CNT_W'(r_addr) < r_count)
    `OKL_ASSERT_IMP(a_count_range, i_clk, i_rst_n, wr_en, !(full && (r_state == S_IDLE)))

endmodule

// File: sv/okl_ram.sv
// ----------------------------------------------------------------------------
// Ordered key list storage
// Synchronous memory, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module okl_ram import okl_pkg::*; #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic                    i_clk,
    input  logic                    i_wr_en,
    input  logic [ADDR_W-1:0]       i_wr_addr,
    input  logic signed [KEY_W-1:0] i_wr_data,
    input  logic                    i_rd_en,
    input  logic [ADDR_W-1:0]       i_rd_addr,
    output logic signed [KEY_W-1:0] o_rd_data
);

    logic signed [KEY_W-1:0] r_mem [DEPTH];
    logic signed [KEY_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: sv/okl_out_stage.sv
// ----------------------------------------------------------------------------
// Ordered key list result register
// Holds one result transaction until the sink takes it.
// ----------------------------------------------------------------------------
module okl_out_stage import okl_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_result   i_res,
    output logic      o_free,
    okl_out_if.source o_out
);

    logic    r_valid;
    logic    n_valid;
    t_result r_res;

    assign o_free = !r_valid || o_out.ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (o_out.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.status      = r_res.status;
    assign o_out.entry_value = r_res.value;
    assign o_out.last        = r_res.last;

endmodule

// File: tb/ordered_key_list_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ordered key list checker
// Watches the request and result channels. Keeps its own newest-first key
// list, works out the results of every accepted request and compares each
// accepted result field by field with the oldest one still waiting.
// ----------------------------------------------------------------------------
module ordered_key_list_checker import okl_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    okl_in_if    i_req,
    okl_out_if   i_res,
    output int   o_fail_count,
    output int   o_pending
);

    logic signed [KEY_W-1:0] held_keys[$];
    t_result                 expected_results[$];

    task automatic predict_list_op(input logic [OP_W-1:0] op,
                                   input logic signed [KEY_W-1:0] key);
        int hit;
        hit = -1;
        case (op)
            OP_INSERT: begin
                if (held_keys.size() >= CAPACITY) begin
                    expected_results.push_back(t_result'{ST_FULL, key, 1'b1});
                end else begin
                    held_keys.push_front(key);
                    expected_results.push_back(t_result'{ST_DONE, key, 1'b1});
                end
            end
            OP_REMOVE: begin
                if (held_keys.size() == 0) begin
                    expected_results.push_back(t_result'{ST_EMPTY, key, 1'b1});
                end else begin
                    foreach (held_keys[i]) begin
                        if (hit < 0 && held_keys[i] == key) begin
                            hit = i;
                        end
                    end
                    if (hit < 0) begin
                        expected_results.push_back(t_result'{ST_NOT_FOUND, key, 1'b1});
                    end else begin
                        held_keys.delete(hit);
                        expected_results.push_back(t_result'{ST_DONE, key, 1'b1});
                    end
                end
            end
            OP_DUMP: begin
                if (held_keys.size() == 0) begin
                    expected_results.push_back(t_result'{ST_EMPTY, '0, 1'b1});
                end else begin
                    foreach (held_keys[i]) begin
                        expected_results.push_back(
                            t_result'{ST_DONE, held_keys[i], i == held_keys.size() - 1});
                    end
                end
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            held_keys.delete();
            expected_results.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result: status %0d value %0d last %0b",
                             $time, i_res.status, i_res.entry_value, i_res.last);
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_res.status !== want.status || i_res.entry_value !== want.value ||
                        i_res.last !== want.last) begin
                        $display({"%0t: mismatch: expected status %0d value %0d last %0b,",
                                  " actual status %0d value %0d last %0b"},
                                 $time, want.status, want.value, want.last,
                                 i_res.status, i_res.entry_value, i_res.last);
                        o_fail_count++;
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                predict_list_op(i_req.op, i_req.key);
            end
        end
        o_pending = expected_results.size();
    end

endmodule

// File: tb/ordered_key_list_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ordered key list testbench
// Drives insert, remove and dump requests: a directed pass over the empty,
// full, not-found and duplicate cases, then random traffic in three phases
// of sender and receiver idling, with a long result hold-off that backs the
// block up. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module ordered_key_list_test;
    import okl_pkg::*;

    localparam int CAPACITY         = 16;
    localparam int RANDOM_PER_PHASE = 110;
    localparam int SEGMENT          = 26;
    localparam int PRESSURE_ITEMS   = 40;
    localparam int LONG_HOLD        = 300;
    localparam int SETTLE_CYCLES    = 2 * CAPACITY + 8;
    localparam int POOL_DEPTH       = 48;

    localparam logic [OP_W-1:0]         OP_UNUSED = 2'd3;
    localparam logic signed [KEY_W-1:0] KEY_MIN   = 32'h8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX   = 32'h7fff_ffff;

    logic clk = 1'b0;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   send_idle_pct;
    int   recv_idle_pct;
    bit   hold_request = 1'b0;
    int   hold_left;

    logic signed [KEY_W-1:0] key_pool[$];

    okl_in_if  req_ch ();
    okl_out_if res_ch ();

    ordered_key_list #(
        .CAPACITY (CAPACITY)
    ) DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (req_ch),
        .o_out   (res_ch)
    );

    ordered_key_list_checker #(
        .CAPACITY (CAPACITY)
    ) checker_0 (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req        (req_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial begin
        #4_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // result side: random stalls, or a long hold-off when requested
    initial begin
        bit hold_seen;
        hold_seen    = 1'b0;
        res_ch.ready = 1'b0;
        hold_left    = 0;
        forever begin
            @(negedge clk);
            if (hold_request && !hold_seen) begin
                hold_seen = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    function automatic logic signed [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (r < 10) begin
            case ($urandom_range(3))
                0:       return KEY_MIN;
                1:       return KEY_MAX;
                2:       return '0;
                default: return '1;
            endcase
        end
        if (r < 40) begin
            return $signed($urandom_range(15)) - 8;
        end
        return $urandom;
    endfunction

    // call at a falling edge; returns at the falling edge after acceptance
    task automatic send_request(input logic [OP_W-1:0] op,
                                input logic signed [KEY_W-1:0] key);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.op    <= op;
        req_ch.key   <= key;
        do @(posedge clk); while (!req_ch.ready);
        @(negedge clk);
        if (op == OP_INSERT) begin
            key_pool.push_back(key);
            if (key_pool.size() > POOL_DEPTH) begin
                void'(key_pool.pop_front());
            end
        end
    endtask

    task automatic wait_for_results();
        req_ch.valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
    endtask

    initial begin
        int                      n;
        int                      phase;
        int                      r;
        int                      idx;
        bit                      filling;
        logic [OP_W-1:0]         op;
        logic signed [KEY_W-1:0] k;

        rst_n         = 1'b0;
        req_ch.valid  = 1'b0;
        req_ch.op     = OP_INSERT;
        req_ch.key    = '0;
        send_idle_pct = 38;
        recv_idle_pct = 48;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_request(OP_DUMP, $urandom);
        send_request(OP_REMOVE, KEY_MIN);
        send_request(OP_INSERT, KEY_MIN);
        send_request(OP_INSERT, KEY_MAX);
        send_request(OP_INSERT, '0);
        send_request(OP_INSERT, '1);
        send_request(OP_INSERT, KEY_MAX);
        send_request(OP_DUMP, '1);
        send_request(OP_REMOVE, 12345);
        send_request(OP_REMOVE, KEY_MAX);
        send_request(OP_REMOVE, KEY_MIN);
        send_request(OP_UNUSED, $urandom);
        for (n = 0; n < CAPACITY - 3; n++) begin
            send_request(OP_INSERT, (n % 2) ? -(n * 1001 + 17) : n * 1001 + 17);
        end
        send_request(OP_INSERT, 32'h5a5a_a5a5);
        send_request(OP_DUMP, '0);
        send_request(OP_REMOVE, KEY_MAX);
        wait_for_results();

        for (phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 48 : 0;
            recv_idle_pct = (phase == 0) ? 48 : (phase == 1) ? 38 : 0;
            if (phase == 2) begin
                hold_request = 1'b1;
                for (n = 0; n < PRESSURE_ITEMS; n++) begin
                    send_request(($urandom_range(3) == 0) ? OP_DUMP : OP_INSERT, pick_key());
                end
                wait_for_results();
            end
            for (n = 0; n < RANDOM_PER_PHASE; n++) begin
                filling = ((n / SEGMENT) % 2) == 0;
                r = $urandom_range(99);
                if (r < (filling ? 50 : 20)) begin
                    op = OP_INSERT;
                end else if (r < 75) begin
                    op = OP_REMOVE;
                end else if (r < 95) begin
                    op = OP_DUMP;
                end else begin
                    op = OP_UNUSED;
                end
                if (op == OP_REMOVE && key_pool.size() != 0 && $urandom_range(99) < 75) begin
                    idx = $urandom_range(key_pool.size() - 1);
                    k   = key_pool[idx];
                    key_pool.delete(idx);
                end else begin
                    k = pick_key();
                end
                send_request(op, k);
            end
            wait_for_results();
        end

        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
